// ===== sv/sht_pkg.sv =====
// ----------------------------------------------------------------------------
// Session handle table package
// Sizes, operation and status codes, and the sequencer states shared by the
// session handle table.
// ----------------------------------------------------------------------------
package sht_pkg;

    localparam int SLOT_COUNT   = 256;
    localparam int SLOT_W       = $clog2(SLOT_COUNT);
    localparam int LIMIT_W      = $clog2(SLOT_COUNT) + 1;
    localparam int SCAN_BITS    = 32;
    localparam int SCAN_POS_W   = $clog2(SCAN_BITS);
    localparam int SCAN_CHUNKS  = SLOT_COUNT / SCAN_BITS;
    localparam int SCAN_CNT_W   = $clog2(SCAN_CHUNKS);
    localparam int TOKEN_W      = 16;
    localparam int SLOT_FIELD_W = 16;
    localparam int ID_W         = TOKEN_W + SLOT_FIELD_W;
    localparam int MAX_SESS_W   = 9;
    localparam int ACTION_W     = 2;
    localparam int STATUS_W     = 3;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [TOKEN_W-1:0]    TOKEN_WRAP        = 16'hFFFF;
    localparam logic [TOKEN_W-1:0]    TOKEN_FIRST       = 16'h0001;
    localparam logic [MAX_SESS_W-1:0] MAX_SESSIONS_RST  = 9'd256;

    // Register index, taken from the word address.
    localparam logic REG_MAX_SESSIONS = 1'b0;

    localparam logic [ACTION_W-1:0] ACT_OPEN   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CLOSE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE    = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_MISMATCH = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_FINISH
    } sht_state_t;

endpackage

// ===== sv/session_handle_table.sv =====
// ----------------------------------------------------------------------------
// Session handle table
// Allocates, closes and looks up generational session handles.
// ----------------------------------------------------------------------------
// One item is taken at a time; in_stall stays high until its result has been
// moved into the output register. Close and lookup read the token memory at
// the accept edge, run the check in ST_CHECK, register its result and move it
// into the output register in ST_FINISH. Open searches for a free slot in
// ST_SCAN: it looks at 32 busy bits per cycle and stops at the first group of
// 32 slots that holds a free slot below the limit, or at the last group, and
// then goes to ST_FINISH. A result that waits in the output register holds back
// only the move of the next result into the output register. The busy bits are
// flops cleared by reset, so no clearing pass is needed after reset.
module session_handle_table
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [sht_pkg::ACTION_W-1:0]        action,
    input  logic [sht_pkg::ID_W-1:0]            session_id,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [sht_pkg::STATUS_W-1:0]        status,
    output logic [sht_pkg::ID_W-1:0]            new_id,
    output logic [sht_pkg::SLOT_W-1:0]          slot_index,
    output logic                                was_open,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sht_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [sht_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [sht_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    sht_pkg::sht_state_t state_reg, state_next;

    logic [sht_pkg::ACTION_W-1:0]     action_reg;
    logic [sht_pkg::ID_W-1:0]         id_reg;
    logic [sht_pkg::SCAN_CNT_W-1:0]   chunk_reg, chunk_next;
    logic [sht_pkg::SLOT_COUNT-1:0]   busy_reg;
    logic [sht_pkg::TOKEN_W-1:0]      cur_token_reg, cur_token_next;
    logic [sht_pkg::TOKEN_W-1:0]      tok_rd_reg;
    logic [sht_pkg::MAX_SESS_W-1:0]   max_sessions_reg;

    logic [sht_pkg::STATUS_W-1:0]     res_status_reg, res_status_next;
    logic [sht_pkg::ID_W-1:0]         res_id_reg, res_id_next;
    logic [sht_pkg::SLOT_W-1:0]       res_slot_reg, res_slot_next;
    logic                             res_open_reg, res_open_next;

    logic                             out_valid_reg, out_valid_next;
    logic [sht_pkg::STATUS_W-1:0]     status_reg;
    logic [sht_pkg::ID_W-1:0]         new_id_reg;
    logic [sht_pkg::SLOT_W-1:0]       slot_index_reg;
    logic                             was_open_reg;

    logic [sht_pkg::TOKEN_W-1:0]      token_mem [sht_pkg::SLOT_COUNT];

    logic                             in_acc;
    logic                             cfg_wr;
    logic                             out_load;
    logic [sht_pkg::LIMIT_W-1:0]      limit;
    logic [sht_pkg::SLOT_FIELD_W-1:0] id_slot;
    logic [sht_pkg::TOKEN_W-1:0]      id_token;
    logic [sht_pkg::SLOT_W-1:0]       id_slot_lo;
    logic                             id_in_range;

    logic [sht_pkg::SCAN_BITS-1:0]    chunk_free;
    logic                             chunk_hit;
    logic [sht_pkg::SCAN_POS_W-1:0]   chunk_pos;
    logic [sht_pkg::SLOT_W-1:0]       free_slot;
    logic [sht_pkg::TOKEN_W-1:0]      token_inc;

    logic                             busy_we;
    logic                             busy_val;
    logic [sht_pkg::SLOT_W-1:0]       busy_idx;
    logic                             mem_we;

    assign in_acc   = in_valid && !in_stall;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_load = (state_reg == sht_pkg::ST_FINISH) && (!out_valid_reg || !out_stall);

    // A limit of zero or above the table size means the whole table.
    always_comb
    begin
        if (max_sessions_reg == '0 ||
            max_sessions_reg > sht_pkg::MAX_SESS_W'(sht_pkg::SLOT_COUNT))
        begin
            limit = sht_pkg::LIMIT_W'(sht_pkg::SLOT_COUNT);
        end
        else
        begin
            limit = sht_pkg::LIMIT_W'(max_sessions_reg);
        end
    end

    assign id_slot     = id_reg[sht_pkg::SLOT_FIELD_W-1:0];
    assign id_token    = id_reg[sht_pkg::ID_W-1:sht_pkg::SLOT_FIELD_W];
    assign id_slot_lo  = id_slot[sht_pkg::SLOT_W-1:0];
    assign id_in_range = id_slot < sht_pkg::SLOT_FIELD_W'(limit);

    // Free slots of the current group of 32 that lie below the limit.
    always_comb
    begin
        logic [sht_pkg::SLOT_W-1:0] idx;
        for (int i = 0; i < sht_pkg::SCAN_BITS; i++)
        begin
            idx = {chunk_reg, sht_pkg::SCAN_POS_W'(i)};
            chunk_free[i] = !busy_reg[idx] && (sht_pkg::LIMIT_W'(idx) < limit);
        end
    end

    // Lowest free slot wins.
    always_comb
    begin
        chunk_hit = 1'b0;
        chunk_pos = '0;
        for (int i = sht_pkg::SCAN_BITS - 1; i >= 0; i--)
        begin
            if (chunk_free[i])
            begin
                chunk_hit = 1'b1;
                chunk_pos = sht_pkg::SCAN_POS_W'(i);
            end
        end
    end

    assign free_slot = {chunk_reg, chunk_pos};

    // The token skips zero and the all-ones value.
    always_comb
    begin
        token_inc = cur_token_reg + sht_pkg::TOKEN_W'(1);
        if (token_inc == sht_pkg::TOKEN_WRAP)
        begin
            token_inc = sht_pkg::TOKEN_FIRST;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sht_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (action) inside
                        sht_pkg::ACT_OPEN:
                            state_next = sht_pkg::ST_SCAN;
                        sht_pkg::ACT_CLOSE, sht_pkg::ACT_LOOKUP:
                            state_next = sht_pkg::ST_CHECK;
                        default:
                            state_next = sht_pkg::ST_IDLE;
                    endcase
                end
            end
            sht_pkg::ST_CHECK:
            begin
                state_next = sht_pkg::ST_FINISH;
            end
            sht_pkg::ST_SCAN:
            begin
                if (chunk_hit || chunk_reg == sht_pkg::SCAN_CNT_W'(sht_pkg::SCAN_CHUNKS - 1))
                begin
                    state_next = sht_pkg::ST_FINISH;
                end
            end
            sht_pkg::ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = sht_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sht_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and state updates per state.
    always_comb
    begin
        chunk_next      = chunk_reg;
        cur_token_next  = cur_token_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_slot_next   = res_slot_reg;
        res_open_next   = res_open_reg;
        busy_we         = 1'b0;
        busy_val        = 1'b0;
        busy_idx        = id_slot_lo;
        mem_we          = 1'b0;
        unique case (state_reg)
            sht_pkg::ST_IDLE:
            begin
                chunk_next = '0;
            end
            sht_pkg::ST_CHECK:
            begin
                res_id_next   = '0;
                res_open_next = 1'b0;
                if (!id_in_range)
                begin
                    res_status_next = sht_pkg::STAT_RANGE;
                    res_slot_next   = '0;
                end
                else if (!busy_reg[id_slot_lo])
                begin
                    if (action_reg == sht_pkg::ACT_CLOSE)
                    begin
                        res_status_next = sht_pkg::STAT_OK;
                        res_slot_next   = id_slot_lo;
                    end
                    else
                    begin
                        res_status_next = sht_pkg::STAT_EMPTY;
                        res_slot_next   = '0;
                    end
                end
                else if (tok_rd_reg != id_token)
                begin
                    res_status_next = sht_pkg::STAT_MISMATCH;
                    res_slot_next   = '0;
                end
                else
                begin
                    res_status_next = sht_pkg::STAT_OK;
                    res_slot_next   = id_slot_lo;
                    if (action_reg == sht_pkg::ACT_CLOSE)
                    begin
                        res_open_next = 1'b1;
                        busy_we       = 1'b1;
                        busy_val      = 1'b0;
                    end
                end
            end
            sht_pkg::ST_SCAN:
            begin
                res_open_next = 1'b0;
                if (chunk_hit)
                begin
                    cur_token_next  = token_inc;
                    busy_we         = 1'b1;
                    busy_val        = 1'b1;
                    busy_idx        = free_slot;
                    mem_we          = 1'b1;
                    res_status_next = sht_pkg::STAT_OK;
                    res_slot_next   = free_slot;
                    res_id_next     = {token_inc,
                                       {(sht_pkg::SLOT_FIELD_W - sht_pkg::SLOT_W){1'b0}},
                                       free_slot};
                end
                else
                begin
                    chunk_next      = chunk_reg + sht_pkg::SCAN_CNT_W'(1);
                    res_status_next = sht_pkg::STAT_FULL;
                    res_slot_next   = '0;
                    res_id_next     = '0;
                end
            end
            sht_pkg::ST_FINISH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        in_stall       = (state_reg != sht_pkg::ST_IDLE);
        out_valid_next = out_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= sht_pkg::ST_IDLE;
            chunk_reg        <= '0;
            busy_reg         <= '0;
            cur_token_reg    <= '0;
            max_sessions_reg <= sht_pkg::MAX_SESSIONS_RST;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chunk_reg     <= chunk_next;
            cur_token_reg <= cur_token_next;
            out_valid_reg <= out_valid_next;
            if (busy_we)
            begin
                busy_reg[busy_idx] <= busy_val;
            end
            if (cfg_wr && paddr[sht_pkg::APB_ADDR_W-1] == sht_pkg::REG_MAX_SESSIONS)
            begin
                max_sessions_reg <= pwdata[sht_pkg::MAX_SESS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            action_reg <= action;
            id_reg     <= session_id;
        end
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_slot_reg   <= res_slot_next;
        res_open_reg   <= res_open_next;
        if (out_load)
        begin
            status_reg     <= res_status_reg;
            new_id_reg     <= res_id_reg;
            slot_index_reg <= res_slot_reg;
            was_open_reg   <= res_open_reg;
        end
    end

    // Token memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            token_mem[free_slot] <= token_inc;
        end
        if (in_acc)
        begin
            tok_rd_reg <= token_mem[session_id[sht_pkg::SLOT_W-1:0]];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[sht_pkg::APB_ADDR_W-1] == sht_pkg::REG_MAX_SESSIONS)
        begin
            prdata = sht_pkg::APB_DATA_W'(max_sessions_reg);
        end
    end

    assign pready     = 1'b1;
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign new_id     = new_id_reg;
    assign slot_index = slot_index_reg;
    assign was_open   = was_open_reg;

endmodule

// ===== tb/session_handle_table_tb.sv =====
// ----------------------------------------------------------------------------
// Session handle table testbench
// Drives open, close and lookup items with random gaps and receiver stalls,
// predicts every result from its own copy of the slot table, token counter
// and session limit, and checks each result field by field. Covers directed
// corner cases, limit changes, a full table, random traffic and slot reuse.
// ----------------------------------------------------------------------------
module session_handle_table_tb;

    localparam logic [sht_pkg::ACTION_W-1:0]   ACT_UNUSED        = 2'd3;
    localparam logic [sht_pkg::APB_ADDR_W-1:0] ADDR_MAX_SESSIONS =
        {sht_pkg::REG_MAX_SESSIONS, 2'b00};
    // Word address of register index 1, which does not exist.
    localparam logic [sht_pkg::APB_ADDR_W-1:0] ADDR_SPARE_REG    = 3'd4;
    localparam int                             SETTLE_CYCLES     = 16;
    localparam int                             MAX_REPORTS       = 10;
    localparam int                             REUSE_ROUNDS      = 30;

    typedef struct packed {
        logic [sht_pkg::STATUS_W-1:0] status;
        logic [sht_pkg::ID_W-1:0]     new_id;
        logic [sht_pkg::SLOT_W-1:0]   slot_index;
        logic                         was_open;
    } session_result_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic [sht_pkg::ACTION_W-1:0]   action;
    logic [sht_pkg::ID_W-1:0]       session_id;
    logic                           out_valid;
    logic                           out_stall;
    logic [sht_pkg::STATUS_W-1:0]   status;
    logic [sht_pkg::ID_W-1:0]       new_id;
    logic [sht_pkg::SLOT_W-1:0]     slot_index;
    logic                           was_open;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [sht_pkg::APB_ADDR_W-1:0] paddr;
    logic [sht_pkg::APB_DATA_W-1:0] pwdata;
    logic [sht_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    // Shadow of the table state.
    bit                             table_busy [sht_pkg::SLOT_COUNT];
    logic [sht_pkg::TOKEN_W-1:0]    table_token [sht_pkg::SLOT_COUNT];
    logic [sht_pkg::TOKEN_W-1:0]    token_counter;
    logic [sht_pkg::MAX_SESS_W-1:0] max_sessions_q;

    session_result_t       expected_results [$];
    int                    error_count;
    bit                    tx_idle_on;
    bit                    rx_idle_on;
    int                    rx_hold;

    session_handle_table uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .session_id (session_id),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .new_id     (new_id),
        .slot_index (slot_index),
        .was_open   (was_open),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int active_limit();
        if (max_sessions_q == '0 || max_sessions_q > sht_pkg::SLOT_COUNT)
            return sht_pkg::SLOT_COUNT;
        return int'(max_sessions_q);
    endfunction

    function automatic int count_free_slots();
        int n;
        n = 0;
        for (int s = 0; s < active_limit(); s++)
            if (!table_busy[s])
                n++;
        return n;
    endfunction

    // Returns an id that names a busy slot below the limit when one exists.
    function automatic logic [sht_pkg::ID_W-1:0] live_session_id();
        int lim;
        int start;
        int s;
        lim   = active_limit();
        start = $urandom_range(0, lim - 1);
        for (int k = 0; k < lim; k++)
        begin
            s = (start + k) % lim;
            if (table_busy[s])
                return {table_token[s], 16'(s)};
        end
        return {table_token[start], 16'(start)};
    endfunction

    function automatic bit predict_action(input logic [sht_pkg::ACTION_W-1:0] act,
                                          input logic [sht_pkg::ID_W-1:0] id,
                                          output session_result_t res);
        int lim;
        int s;
        int slot_n;
        logic [sht_pkg::TOKEN_W-1:0] tok;
        res    = '0;
        lim    = active_limit();
        slot_n = int'(id[15:0]);
        tok    = id[31:16];
        if (act == sht_pkg::ACT_OPEN)
        begin
            s = 0;
            while (s < lim && table_busy[s])
                s++;
            if (s >= lim)
            begin
                res.status = sht_pkg::STAT_FULL;
                return 1'b1;
            end
            token_counter = token_counter + 1'b1;
            if (token_counter == sht_pkg::TOKEN_WRAP)
                token_counter = sht_pkg::TOKEN_FIRST;
            table_busy[s]  = 1'b1;
            table_token[s] = token_counter;
            res.status     = sht_pkg::STAT_OK;
            res.new_id     = {token_counter, 16'(s)};
            res.slot_index = sht_pkg::SLOT_W'(s);
            return 1'b1;
        end
        if (act == sht_pkg::ACT_CLOSE || act == sht_pkg::ACT_LOOKUP)
        begin
            if (slot_n >= lim)
                res.status = sht_pkg::STAT_RANGE;
            else if (!table_busy[slot_n])
            begin
                if (act == sht_pkg::ACT_CLOSE)
                begin
                    res.status     = sht_pkg::STAT_OK;
                    res.slot_index = sht_pkg::SLOT_W'(slot_n);
                end
                else
                    res.status = sht_pkg::STAT_EMPTY;
            end
            else if (table_token[slot_n] != tok)
                res.status = sht_pkg::STAT_MISMATCH;
            else
            begin
                res.status     = sht_pkg::STAT_OK;
                res.slot_index = sht_pkg::SLOT_W'(slot_n);
                if (act == sht_pkg::ACT_CLOSE)
                begin
                    table_busy[slot_n] = 1'b0;
                    res.was_open       = 1'b1;
                end
            end
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Sends one item and leaves valid high after the accepting edge, so that
    // a following item can go out back to back.
    task automatic issue_action(input logic [sht_pkg::ACTION_W-1:0] act,
                                input logic [sht_pkg::ID_W-1:0] id);
        int gap;
        session_result_t res;
        gap = tx_idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        action     <= act;
        session_id <= id;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (predict_action(act, id, res))
            expected_results.push_back(res);
    endtask

    task automatic pause_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // An unused action gives no result, so allow for one still in flight.
    task automatic settle_table();
        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [sht_pkg::APB_ADDR_W-1:0] addr,
                             input logic [sht_pkg::APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr[2] == sht_pkg::REG_MAX_SESSIONS)
            max_sessions_q = data[sht_pkg::MAX_SESS_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_limit(input logic [sht_pkg::MAX_SESS_W-1:0] limit);
        settle_table();
        write_reg(ADDR_MAX_SESSIONS, sht_pkg::APB_DATA_W'(limit));
    endtask

    task automatic note_error(input string msg);
        if (error_count < MAX_REPORTS)
            $display("ERROR: %s", msg);
        error_count++;
    endtask

    // Result checker and receiver stall driver.
    initial
    begin
        session_result_t got;
        session_result_t exp_res;
        int rx_wait;
        rx_wait = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got = {status, new_id, slot_index, was_open};
                if (expected_results.size() == 0)
                    note_error($sformatf("unexpected result status %0d new_id %h slot %0d open %0b",
                                         got.status, got.new_id, got.slot_index, got.was_open));
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (got !== exp_res)
                        note_error($sformatf({"result mismatch: expected status %0d new_id %h ",
                                              "slot %0d open %0b, got status %0d new_id %h ",
                                              "slot %0d open %0b"},
                                             exp_res.status, exp_res.new_id, exp_res.slot_index,
                                             exp_res.was_open, got.status, got.new_id,
                                             got.slot_index, got.was_open));
                end
                rx_wait = rx_idle_on ? $urandom_range(0, 7) : 0;
            end
            @(negedge clk);
            if (rx_hold > 0)
            begin
                out_stall <= 1'b1;
                rx_hold--;
            end
            else if (rx_wait > 0)
            begin
                out_stall <= 1'b1;
                rx_wait--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic test_directed_cases();
        issue_action(sht_pkg::ACT_LOOKUP, 32'h0000_0000);
        issue_action(sht_pkg::ACT_CLOSE,  32'h0000_0000);
        issue_action(sht_pkg::ACT_CLOSE,  32'hFFFF_00FF);
        issue_action(sht_pkg::ACT_LOOKUP, 32'h0000_0100);
        issue_action(sht_pkg::ACT_CLOSE,  32'hFFFF_FFFF);
        issue_action(ACT_UNUSED,          32'hFFFF_FFFF);
        issue_action(sht_pkg::ACT_OPEN,   32'hFFFF_FFFF);
        issue_action(sht_pkg::ACT_OPEN,   32'h0000_0000);
        issue_action(sht_pkg::ACT_LOOKUP, {table_token[0], 16'd0});
        issue_action(sht_pkg::ACT_LOOKUP, {table_token[0] + 16'd1, 16'd0});
        issue_action(sht_pkg::ACT_CLOSE,  {16'hFFFF, 16'd1});
        issue_action(sht_pkg::ACT_LOOKUP, {16'h0000, 16'd1});
        issue_action(sht_pkg::ACT_CLOSE,  {table_token[1], 16'd1});
        issue_action(sht_pkg::ACT_LOOKUP, {table_token[1], 16'd1});
        issue_action(sht_pkg::ACT_OPEN,   32'h5A5A_A5A5);
        issue_action(sht_pkg::ACT_CLOSE,  {table_token[0], 16'd0});
        issue_action(sht_pkg::ACT_CLOSE,  {table_token[0], 16'd0});
        issue_action(sht_pkg::ACT_OPEN,   32'h0000_0000);
        issue_action(sht_pkg::ACT_LOOKUP, {table_token[1], 16'd1});
    endtask

    task automatic test_limit_changes();
        set_limit(9'd2);
        issue_action(sht_pkg::ACT_OPEN,   32'h0000_0000);
        issue_action(sht_pkg::ACT_LOOKUP, {table_token[1], 16'd1});
        issue_action(sht_pkg::ACT_LOOKUP, 32'h0000_0002);
        set_limit(9'd0);
        issue_action(sht_pkg::ACT_OPEN,   32'h0000_0000);
        issue_action(sht_pkg::ACT_LOOKUP, 32'h0000_00FF);
        set_limit(9'd511);
        issue_action(sht_pkg::ACT_LOOKUP, 32'h0000_00FF);
        issue_action(sht_pkg::ACT_CLOSE,  32'h0000_0100);
        // Slots above a lowered limit stay busy but cannot be reached.
        set_limit(9'd1);
        issue_action(sht_pkg::ACT_LOOKUP, {table_token[2], 16'd2});
        issue_action(sht_pkg::ACT_OPEN,   32'h0000_0000);
        settle_table();
        write_reg(ADDR_SPARE_REG, 32'd100);
        issue_action(sht_pkg::ACT_OPEN,   32'h0000_0000);
        set_limit(9'd3);
        issue_action(sht_pkg::ACT_LOOKUP, {table_token[2], 16'd2});
        issue_action(sht_pkg::ACT_CLOSE,  {table_token[2], 16'd2});
    endtask

    task automatic test_full_table();
        set_limit(sht_pkg::MAX_SESSIONS_RST);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        // Hold the receiver off while opens keep coming, so the input stalls.
        rx_hold = 80;
        while (count_free_slots() > 0)
            issue_action(sht_pkg::ACT_OPEN, $urandom());
        issue_action(sht_pkg::ACT_OPEN, $urandom());
        issue_action(sht_pkg::ACT_OPEN, $urandom());
        issue_action(sht_pkg::ACT_CLOSE, {table_token[128], 16'd128});
        issue_action(sht_pkg::ACT_OPEN, 32'h0000_0000);
        issue_action(sht_pkg::ACT_LOOKUP, {table_token[255], 16'd255});
        tx_idle_on = 1'b1;
        pause_until_drained();
    endtask

    task automatic test_random_traffic(input logic [sht_pkg::MAX_SESS_W-1:0] limit,
                                       input int n_items, input bit idles);
        int done;
        int pick;
        int lim;
        logic [sht_pkg::ACTION_W-1:0] act;
        logic [sht_pkg::ID_W-1:0] id;
        set_limit(limit);
        tx_idle_on = idles;
        rx_idle_on = idles;
        done = 0;
        while (done < n_items)
        begin
            pick = $urandom_range(0, 99);
            lim  = active_limit();
            act  = $urandom_range(0, 1) ? sht_pkg::ACT_CLOSE : sht_pkg::ACT_LOOKUP;
            id   = live_session_id();
            if (pick < 40)
            begin
                act = sht_pkg::ACT_OPEN;
                id  = $urandom();
            end
            else if (pick < 80)
                ;
            else if (pick < 86)
                id = $urandom();
            else if (pick < 92)
                id[31:16] ^= 16'($urandom_range(1, 16'hFFFF));
            else if (pick < 97)
                id[15:0] = 16'(lim - 1 + $urandom_range(0, 2));
            else
                act = ACT_UNUSED;
            issue_action(act, id);
            if (act != ACT_UNUSED)
                done++;
            if ($urandom_range(0, 59) == 0)
                pause_until_drained();
            if ($urandom_range(0, 299) == 0)
                rx_hold = 40;
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Opens and closes slot 0 over and over; each open issues a fresh token,
    // so ids from earlier rounds no longer match.
    task automatic test_slot_reuse();
        set_limit(9'd1);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        if (table_busy[0])
            issue_action(sht_pkg::ACT_CLOSE, {table_token[0], 16'd0});
        repeat (REUSE_ROUNDS)
        begin
            issue_action(sht_pkg::ACT_OPEN, 32'h0000_0000);
            issue_action(sht_pkg::ACT_CLOSE, {table_token[0], 16'd0});
        end
        repeat (3)
        begin
            issue_action(sht_pkg::ACT_OPEN, 32'h0000_0000);
            issue_action(sht_pkg::ACT_LOOKUP, {sht_pkg::TOKEN_WRAP, 16'd0});
            issue_action(sht_pkg::ACT_LOOKUP, {table_token[0], 16'd0});
            issue_action(sht_pkg::ACT_CLOSE, {table_token[0], 16'd0});
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        action         = sht_pkg::ACT_OPEN;
        session_id     = '0;
        out_stall      = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        error_count    = 0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        rx_hold        = 0;
        token_counter  = '0;
        max_sessions_q = sht_pkg::MAX_SESSIONS_RST;
        for (int s = 0; s < sht_pkg::SLOT_COUNT; s++)
        begin
            table_busy[s]  = 1'b0;
            table_token[s] = '0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_limit_changes();
        test_full_table();
        test_random_traffic(9'd0,   130, 1'b1);
        test_random_traffic(9'd1,   100, 1'b1);
        test_random_traffic(9'd3,   120, 1'b0);
        test_random_traffic(9'd40,  150, 1'b1);
        test_random_traffic(9'd300, 120, 1'b1);
        test_random_traffic(9'd17,  120, 1'b0);
        test_slot_reuse();
        test_random_traffic(9'd511, 130, 1'b1);
        test_random_traffic(9'd256, 120, 1'b1);

        settle_table();
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
